/* design/rdc_pkg.sv */
// Package with the codes, widths and result type of the rotator direction controller.
package rdc_pkg;

  localparam int ELAPSED_W   = 22;
  localparam int TIMEOUT_W   = 12;
  localparam int REV_DELAY_W = 16;
  localparam int CODE_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = {ELAPSED_W{1'b1}};
  localparam logic [ELAPSED_W-1:0] MS_PER_SECOND = ELAPSED_W'(1000);
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = TIMEOUT_W'(60);
  localparam logic [REV_DELAY_W-1:0] REV_DELAY_RESET = REV_DELAY_W'(1000);

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REV_DELAY = CFG_IDX_W'(1);

  typedef logic [1:0] dir_t;

  localparam dir_t DIR_NONE = 2'd0;
  localparam dir_t DIR_CW   = 2'd1;
  localparam dir_t DIR_CCW  = 2'd2;

  typedef struct packed {
    logic drive_ccw;
    logic drive_cw;
    logic request_ok;
    dir_t shown_direction;
    logic showing_pending;
    logic request_done;
    logic status_shown;
  } res_t;

endpackage

/* design/rotator_direction_controller_unit.sv */
// Top level of the rotator direction controller: motor state, timeout, reversal wait, output queue.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_tvalid/in_tready | tuser: cmd; tdata: request_code
//  out     | output    | out_tvalid/tready   | tuser: status_shown, request_done; tdata: rest
//  cfg     | input     | cfg_we              | cfg_addr register index, cfg_wdata value
//
// Each item is processed in the cycle of its transfer; a result, if any, is registered. One item
// per cycle is sustained unless output stalls fill the two-entry output queue (result register and
// skid register), which keeps input accepted while one result is stalled. in_tready drops only when
// both entries hold results. Reset is synchronous and active low; no clearing pass is needed.
module rotator_direction_controller_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic                          in_tuser,   // [0] cmd
  input  logic [rdc_pkg::CODE_W-1:0]    in_tdata,   // [7:0] request_code
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [1:0]                    out_tuser,  // [0] status_shown, [1] request_done
  output logic [7:0]                    out_tdata,  // [0] showing_pending, [2:1] shown_direction,
                                                    // [3] request_ok, [4] drive_cw,
                                                    // [5] drive_ccw, [7:6] zero
  input  logic                          cfg_we,
  input  logic [rdc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rdc_pkg::*;

  logic [ELAPSED_W-1:0]   timeout_ms_r;
  logic [REV_DELAY_W-1:0] rev_delay_r;

  dir_t                 moving_r, moving_nxt;
  dir_t                 pending_r, pending_nxt;
  dir_t                 previous_r, previous_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 wait_rep_r, wait_rep_nxt;
  logic                 cw_r, cw_nxt;
  logic                 ccw_r, ccw_nxt;

  res_t res_r, skid_r, res_new;
  logic out_vld_r, skid_vld_r;
  logic has_res, emit_status, emit_done, emit_ok;
  logic accept, take, reversal;
  logic [ELAPSED_W-1:0] elapsed_inc;

  assign accept    = in_tvalid && in_tready;
  assign take      = out_vld_r && out_tready;
  assign in_tready = !skid_vld_r;

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign reversal    = (previous_r == DIR_CW && pending_r == DIR_CCW) ||
                       (previous_r == DIR_CCW && pending_r == DIR_CW);

  always_comb begin
    moving_nxt   = moving_r;
    pending_nxt  = pending_r;
    previous_nxt = previous_r;
    elapsed_nxt  = elapsed_r;
    wait_rep_nxt = wait_rep_r;
    cw_nxt       = cw_r;
    ccw_nxt      = ccw_r;
    has_res      = 1'b0;
    emit_status  = 1'b0;
    emit_done    = 1'b0;
    emit_ok      = 1'b0;
    if (in_tuser == CMD_TICK) begin
      elapsed_nxt = elapsed_inc;
      if (moving_r != DIR_NONE && elapsed_inc >= timeout_ms_r) begin
        cw_nxt       = 1'b0;
        ccw_nxt      = 1'b0;
        elapsed_nxt  = '0;
        previous_nxt = moving_r;
        moving_nxt   = DIR_NONE;
        has_res      = 1'b1;
        emit_status  = 1'b1;
      end else if (pending_r != DIR_NONE) begin
        if (reversal && elapsed_inc <= ELAPSED_W'(rev_delay_r)) begin
          if (!wait_rep_r) begin
            wait_rep_nxt = 1'b1;
            has_res      = 1'b1;
            emit_status  = 1'b1;
          end
        end else begin
          if (pending_r == DIR_CW) begin
            cw_nxt = 1'b1;
          end else if (pending_r == DIR_CCW) begin
            ccw_nxt = 1'b1;
          end
          elapsed_nxt = '0;
          moving_nxt  = pending_r;
          pending_nxt = DIR_NONE;
          has_res     = 1'b1;
          emit_status = 1'b1;
        end
      end
    end else begin
      has_res   = 1'b1;
      emit_done = 1'b1;
      if (in_tdata == CODE_W'(DIR_NONE)) begin
        pending_nxt = DIR_NONE;
      end
      if (in_tdata == CODE_W'(moving_r)) begin
        emit_status = 1'b1;
        emit_ok     = 1'b1;
      end else begin
        if (moving_r != DIR_NONE) begin
          cw_nxt       = 1'b0;
          ccw_nxt      = 1'b0;
          elapsed_nxt  = '0;
          previous_nxt = moving_r;
          moving_nxt   = DIR_NONE;
        end
        if (in_tdata == CODE_W'(DIR_NONE)) begin
          emit_status = 1'b1;
          emit_ok     = 1'b1;
        end else if (in_tdata == CODE_W'(DIR_CW) || in_tdata == CODE_W'(DIR_CCW)) begin
          pending_nxt  = dir_t'(in_tdata[1:0]);
          wait_rep_nxt = 1'b0;
          emit_ok      = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_new                 = '0;
    res_new.status_shown    = emit_status;
    res_new.request_done    = emit_done;
    res_new.request_ok      = emit_ok;
    res_new.drive_cw        = cw_nxt;
    res_new.drive_ccw       = ccw_nxt;
    if (emit_status) begin
      if (pending_nxt != DIR_NONE) begin
        res_new.showing_pending = 1'b1;
        res_new.shown_direction = pending_nxt;
      end else begin
        res_new.shown_direction = moving_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ms_r <= ELAPSED_W'(TIMEOUT_RESET) * MS_PER_SECOND;
      rev_delay_r  <= REV_DELAY_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == REG_TIMEOUT) begin
        timeout_ms_r <= ELAPSED_W'(cfg_wdata[TIMEOUT_W-1:0]) * MS_PER_SECOND;
      end else if (cfg_addr == REG_REV_DELAY) begin
        rev_delay_r <= cfg_wdata[REV_DELAY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r   <= DIR_NONE;
      pending_r  <= DIR_NONE;
      previous_r <= DIR_NONE;
      elapsed_r  <= '0;
      wait_rep_r <= 1'b0;
      cw_r       <= 1'b0;
      ccw_r      <= 1'b0;
    end else if (accept) begin
      moving_r   <= moving_nxt;
      pending_r  <= pending_nxt;
      previous_r <= previous_nxt;
      elapsed_r  <= elapsed_nxt;
      wait_rep_r <= wait_rep_nxt;
      cw_r       <= cw_nxt;
      ccw_r      <= ccw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (out_vld_r && !take) begin
      if (accept && has_res) begin
        skid_vld_r <= 1'b1;
      end
    end else begin
      out_vld_r <= accept && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (take) begin
        res_r <= skid_r;
      end
    end else if (out_vld_r && !take) begin
      if (accept && has_res) begin
        skid_r <= res_new;
      end
    end else if (accept && has_res) begin
      res_r <= res_new;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = {res_r.request_done, res_r.status_shown};
  assign out_tdata  = {2'b00, res_r.drive_ccw, res_r.drive_cw, res_r.request_ok,
                       res_r.shown_direction, res_r.showing_pending};

  a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cw_r && ccw_r))
    else $error("Both drive levels are high.");

  a_drive_matches_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (cw_r == (moving_r == DIR_CW)) && (ccw_r == (moving_r == DIR_CCW)))
    else $error("Drive levels disagree with the moving direction.");

  a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("Skid register holds a result while the output register is empty.");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_tready) |=> (out_vld_r && !skid_vld_r))
    else $error("Skid register did not move into the output register after a transfer.");

endmodule

/* tb/rdc_status_checker.sv */
// Checker that predicts the rotator controller's status results and compares every result transfer.
module rdc_status_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic                           in_tuser,
  input  logic [rdc_pkg::CODE_W-1:0]     in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [1:0]                     out_tuser,
  input  logic [7:0]                     out_tdata,
  input  logic                           cfg_we,
  input  logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             failures,
  output int                             results_due
);
  import rdc_pkg::*;

  typedef struct {
    logic status_shown;
    logic showing_pending;
    dir_t shown_direction;
    logic request_done;
    logic request_ok;
    logic drive_cw;
    logic drive_ccw;
  } rotator_report_t;

  rotator_report_t status_due[$];
  int fail_total = 0;
  int due_count = 0;

  logic [TIMEOUT_W-1:0]   timeout_s;
  logic [REV_DELAY_W-1:0] rev_delay;
  dir_t                   moving_dir;
  dir_t                   queued_dir;
  dir_t                   last_dir;
  logic [ELAPSED_W-1:0]   elapsed;
  logic                   wait_told;
  logic                   cw_level;
  logic                   ccw_level;

  assign failures    = fail_total;
  assign results_due = due_count;

  function automatic rotator_report_t form_report(logic shown, logic done, logic ok);
    rotator_report_t r;
    r.status_shown    = shown;
    r.showing_pending = 1'b0;
    r.shown_direction = DIR_NONE;
    if (shown) begin
      if (queued_dir != DIR_NONE) begin
        r.showing_pending = 1'b1;
        r.shown_direction = queued_dir;
      end else begin
        r.shown_direction = moving_dir;
      end
    end
    r.request_done = done;
    r.request_ok   = ok;
    r.drive_cw     = cw_level;
    r.drive_ccw    = ccw_level;
    return r;
  endfunction

  task automatic stop_motor();
    cw_level   = 1'b0;
    ccw_level  = 1'b0;
    elapsed    = '0;
    last_dir   = moving_dir;
    moving_dir = DIR_NONE;
  endtask

  task automatic advance_rotator(input logic cmd, input logic [CODE_W-1:0] code,
                                 output logic made, output rotator_report_t r);
    logic reversing;
    made = 1'b1;
    r = form_report(1'b0, 1'b0, 1'b0);
    if (cmd == CMD_TICK) begin
      if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
      reversing = (last_dir == DIR_CW && queued_dir == DIR_CCW) ||
                  (last_dir == DIR_CCW && queued_dir == DIR_CW);
      if (moving_dir != DIR_NONE &&
          32'(elapsed) >= 32'(timeout_s) * 32'(MS_PER_SECOND)) begin
        stop_motor();
        r = form_report(1'b1, 1'b0, 1'b0);
      end else if (queued_dir == DIR_NONE) begin
        made = 1'b0;
      end else if (reversing && 32'(elapsed) <= 32'(rev_delay)) begin
        if (!wait_told) begin
          wait_told = 1'b1;
          r = form_report(1'b1, 1'b0, 1'b0);
        end else begin
          made = 1'b0;
        end
      end else begin
        if (queued_dir == DIR_CW) cw_level = 1'b1;
        else if (queued_dir == DIR_CCW) ccw_level = 1'b1;
        elapsed    = '0;
        moving_dir = queued_dir;
        queued_dir = DIR_NONE;
        r = form_report(1'b1, 1'b0, 1'b0);
      end
    end else begin
      if (code == CODE_W'(DIR_NONE)) queued_dir = DIR_NONE;
      if (code == CODE_W'(moving_dir)) begin
        r = form_report(1'b1, 1'b1, 1'b1);
      end else begin
        if (moving_dir != DIR_NONE) stop_motor();
        if (code == CODE_W'(DIR_NONE)) begin
          r = form_report(1'b1, 1'b1, 1'b1);
        end else if (code == CODE_W'(DIR_CW) || code == CODE_W'(DIR_CCW)) begin
          queued_dir = dir_t'(code);
          wait_told  = 1'b0;
          r = form_report(1'b0, 1'b1, 1'b1);
        end else begin
          r = form_report(1'b0, 1'b1, 1'b0);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    rotator_report_t got;
    rotator_report_t want;
    logic made;
    if (!rst_n) begin
      timeout_s  = TIMEOUT_RESET;
      rev_delay  = REV_DELAY_RESET;
      moving_dir = DIR_NONE;
      queued_dir = DIR_NONE;
      last_dir   = DIR_NONE;
      elapsed    = '0;
      wait_told  = 1'b0;
      cw_level   = 1'b0;
      ccw_level  = 1'b0;
      status_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status_shown    = out_tuser[0];
        got.request_done    = out_tuser[1];
        got.showing_pending = out_tdata[0];
        got.shown_direction = out_tdata[2:1];
        got.request_ok      = out_tdata[3];
        got.drive_cw        = out_tdata[4];
        got.drive_ccw       = out_tdata[5];
        if (status_due.size() == 0) begin
          $error("Result transfer arrived while no result was expected.");
          fail_total++;
        end else begin
          want = status_due.pop_front();
          check_field("status_shown", want.status_shown, got.status_shown);
          check_field("showing_pending", want.showing_pending, got.showing_pending);
          check_field("shown_direction", want.shown_direction, got.shown_direction);
          check_field("request_done", want.request_done, got.request_done);
          check_field("request_ok", want.request_ok, got.request_ok);
          check_field("drive_cw", want.drive_cw, got.drive_cw);
          check_field("drive_ccw", want.drive_ccw, got.drive_ccw);
        end
      end
      if (cfg_we) begin
        if (cfg_addr == REG_TIMEOUT) timeout_s = cfg_wdata[TIMEOUT_W-1:0];
        else if (cfg_addr == REG_REV_DELAY) rev_delay = cfg_wdata[REV_DELAY_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        advance_rotator(in_tuser, in_tdata, made, want);
        if (made) status_due.push_back(want);
      end
    end
    due_count <= status_due.size();
  end

endmodule

/* tb/tb_top.sv */
// Top of the rotator controller testbench: clock, reset, stimulus, stalls, watchdog and verdict.
module tb_top;
  import rdc_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam logic [CODE_W-1:0] CODE_STOP     = CODE_W'(DIR_NONE);
  localparam logic [CODE_W-1:0] CODE_CW       = CODE_W'(DIR_CW);
  localparam logic [CODE_W-1:0] CODE_CCW      = CODE_W'(DIR_CCW);
  localparam logic [CODE_W-1:0] CODE_BAD_LOW  = CODE_W'(3);
  localparam logic [CODE_W-1:0] CODE_BAD_HIGH = {CODE_W{1'b1}};

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic                  in_tuser   = 1'b0;
  logic [CODE_W-1:0]     in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [1:0]            out_tuser;
  logic [7:0]            out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int fail_count;
  int results_due;
  int quiet_cycles = 0;
  int stall_left   = 0;
  int cur_delay    = 1000;
  bit calm         = 1'b0;

  always #5 clk = ~clk;

  rotator_direction_controller_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  rdc_status_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .failures(fail_count), .results_due(results_due)
  );

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [CODE_W-1:0] code);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(CMD_TICK, CODE_W'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] timeout_word,
                            input logic [CFG_DATA_W-1:0] delay_word);
    settle();
    write_reg(REG_TIMEOUT, timeout_word);
    write_reg(REG_REV_DELAY, delay_word);
    cfg_we    <= 1'b0;
    cur_delay = delay_word;
  endtask

  // Each round is one request followed by a run of ticks.
  task automatic random_traffic(input int budget);
    int done_items;
    int pick;
    int run_len;
    logic [CODE_W-1:0] code;
    done_items = 0;
    while (done_items < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) code = CODE_STOP;
      else if (pick < 52) code = CODE_CW;
      else if (pick < 86) code = CODE_CCW;
      else code = CODE_W'($urandom_range(0, 255));
      send_item(CMD_REQUEST, code);
      done_items++;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        run_len = $urandom_range(0, 4);
      end else if (pick < 93) begin
        run_len = $urandom_range(0, (cur_delay < 60 ? cur_delay : 60) + 3);
      end else begin
        run_len = $urandom_range(5, 40);
      end
      done_items += run_len;
      send_ticks(run_len);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_item(CMD_TICK, CODE_BAD_HIGH);
    send_item(CMD_REQUEST, CODE_CW);
    send_item(CMD_TICK, CODE_STOP);
    send_item(CMD_REQUEST, CODE_CW);
    send_item(CMD_REQUEST, CODE_BAD_LOW);
    send_item(CMD_TICK, CODE_STOP);
    send_item(CMD_REQUEST, CODE_BAD_HIGH);
    send_item(CMD_REQUEST, CODE_CCW);
    send_item(CMD_TICK, CODE_STOP);
    send_item(CMD_TICK, CODE_STOP);
    send_item(CMD_REQUEST, CODE_STOP);
    send_item(CMD_REQUEST, CODE_CW);
    send_item(CMD_TICK, CODE_STOP);
    send_item(CMD_REQUEST, CODE_STOP);

    set_config('0, '0);
    send_item(CMD_REQUEST, CODE_CCW);
    send_ticks(2);
    send_item(CMD_REQUEST, CODE_CW);
    send_ticks(2);
    random_traffic(150);

    // A one-second timeout is reached by one long run of ticks.
    set_config(CFG_DATA_W'(1), CFG_DATA_W'(3));
    send_item(CMD_REQUEST, CODE_CW);
    send_ticks(1010);
    random_traffic(150);

    set_config({CFG_DATA_W{1'b1}}, '0);
    send_item(CMD_REQUEST, CODE_CW);
    send_ticks(1);
    set_config({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}});
    send_item(CMD_REQUEST, CODE_CCW);
    send_ticks(40);
    random_traffic(100);

    set_config(16'hA001, CFG_DATA_W'($urandom_range(0, 40)));
    random_traffic(55);
    set_config(CFG_DATA_W'($urandom_range(0, 65535)), CFG_DATA_W'($urandom_range(0, 40)));
    random_traffic(55);
    set_config(CFG_DATA_W'({$urandom_range(0, 15), 12'(0)}) | CFG_DATA_W'($urandom_range(0, 3)),
               CFG_DATA_W'($urandom_range(0, 40)));
    calm = 1'b1;
    random_traffic(55);

    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
